FILE: rtl/ifdc_pkg.sv
// ----------------------------------------------------------------------------
// ifdc_pkg: shared types and constants of the IPv4 flow direction classifier
// Field widths, register indexes, drop reasons and the header summary and
// flow result records.
// ----------------------------------------------------------------------------
`default_nettype none

package ifdc_pkg;

    // Sizes of the blocked lists
    localparam int NUM_BLOCKED_PROTOCOLS = 4;
    localparam int NUM_BLOCKED_PORTS     = 4;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int PROTO_W = 8;
    localparam int LEN_W   = 16;
    localparam int HW_W    = 2;
    localparam int CNT_W   = 3;
    localparam int FLAGS_W = 4;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;

    // Mode flag bit positions
    localparam int FLAG_CTRL_FILTER = 0;
    localparam int FLAG_SUBNET      = 1;
    localparam int FLAG_OWN_VALID   = 2;
    localparam int FLAG_CHOOSY      = 3;

    // Protocols that carry ports
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // Link layer direction hints
    localparam logic [HW_W-1:0] HW_IN  = 2'd0;
    localparam logic [HW_W-1:0] HW_OUT = 2'd1;

    // Special addresses
    localparam logic [15:0]       CTRL_NET_HI    = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_BROADCAST = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] ADDR_LOOPBACK  = 32'h7F00_0001;
    localparam logic [3:0]        MCAST_NIBBLE   = 4'hE;

    // First dynamic port
    localparam logic [PORT_W-1:0] DYN_PORT_MIN = 16'd49152;

    typedef enum logic [IDX_W-1:0] {
        CFG_MODE_FLAGS    = 3'd0,
        CFG_NET_MASK      = 3'd1,
        CFG_NET_ADDR      = 3'd2,
        CFG_OWN_IP        = 3'd3,
        CFG_GATEWAY_IP    = 3'd4,
        CFG_BLOCKED_PROTO = 3'd5,
        CFG_BLOCKED_CNT   = 3'd6,
        CFG_BLOCKED_PORTS = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DROP_NONE       = 3'd0,
        DROP_CONTROL    = 3'd1,
        DROP_PROTOCOL   = 3'd2,
        DROP_UNDECIDED  = 3'd3,
        DROP_ROUTER     = 3'd4,
        DROP_PORT       = 3'd5
    } t_drop_reason;

    typedef struct packed {
        logic [FLAGS_W-1:0]                   mode_flags;
        logic [ADDR_W-1:0]                    net_mask;
        logic [ADDR_W-1:0]                    net_addr;
        logic [ADDR_W-1:0]                    own_ip;
        logic [ADDR_W-1:0]                    gateway_ip;
        logic [NUM_BLOCKED_PROTOCOLS*PROTO_W-1:0] blocked_protocols;
        logic [CNT_W-1:0]                     blocked_protocol_count;
        logic [NUM_BLOCKED_PORTS*PORT_W-1:0]  blocked_ports;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_ip;
        logic [ADDR_W-1:0]  dst_ip;
        logic [PROTO_W-1:0] protocol;
        logic [PORT_W-1:0]  src_l4_port;
        logic [PORT_W-1:0]  dst_l4_port;
        logic [LEN_W-1:0]   total_length;
        logic [HW_W-1:0]    hw_dir;
    } t_in_item;

    typedef struct packed {
        logic               keep;
        t_drop_reason       drop_reason;
        logic               outgoing;
        logic [ADDR_W-1:0]  flow_src;
        logic [ADDR_W-1:0]  flow_dst;
        logic [PORT_W-1:0]  flow_src_port;
        logic [PORT_W-1:0]  flow_dst_port;
        logic [PROTO_W-1:0] flow_protocol;
        logic               counts_as_sent;
        logic [LEN_W-1:0]   byte_count;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/ifdc_req_if.sv
// ----------------------------------------------------------------------------
// ifdc_req_if: header summary request channel
// Valid/ready handshake with one IPv4 header summary per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifdc_req_if;
    logic                          valid;
    logic                          ready;
    logic [ifdc_pkg::ADDR_W-1:0]   src_ip;
    logic [ifdc_pkg::ADDR_W-1:0]   dst_ip;
    logic [ifdc_pkg::PROTO_W-1:0]  protocol;
    logic [ifdc_pkg::PORT_W-1:0]   src_l4_port;
    logic [ifdc_pkg::PORT_W-1:0]   dst_l4_port;
    logic [ifdc_pkg::LEN_W-1:0]    total_length;
    logic [ifdc_pkg::HW_W-1:0]     hw_dir;

    modport source (
        output valid, src_ip, dst_ip, protocol, src_l4_port, dst_l4_port,
               total_length, hw_dir,
        input  ready
    );
    modport sink (
        input  valid, src_ip, dst_ip, protocol, src_l4_port, dst_l4_port,
               total_length, hw_dir,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/ifdc_rsp_if.sv
// ----------------------------------------------------------------------------
// ifdc_rsp_if: flow decision result channel
// Valid/ready handshake with one keep/drop decision and flow key per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifdc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          keep;
    logic [2:0]                    drop_reason;
    logic                          outgoing;
    logic [ifdc_pkg::ADDR_W-1:0]   flow_src;
    logic [ifdc_pkg::ADDR_W-1:0]   flow_dst;
    logic [ifdc_pkg::PORT_W-1:0]   flow_src_port;
    logic [ifdc_pkg::PORT_W-1:0]   flow_dst_port;
    logic [ifdc_pkg::PROTO_W-1:0]  flow_protocol;
    logic                          counts_as_sent;
    logic [ifdc_pkg::LEN_W-1:0]    byte_count;

    modport source (
        output valid, keep, drop_reason, outgoing, flow_src, flow_dst,
               flow_src_port, flow_dst_port, flow_protocol, counts_as_sent,
               byte_count,
        input  ready
    );
    modport sink (
        input  valid, keep, drop_reason, outgoing, flow_src, flow_dst,
               flow_src_port, flow_dst_port, flow_protocol, counts_as_sent,
               byte_count,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/ifdc_decide.sv
// ----------------------------------------------------------------------------
// ifdc_decide: keep/drop decision and flow key
// Control-address filter, protocol block, direction choice, router drop,
// dynamic port zeroing and port block, all in one combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ifdc_decide (
    input  wire ifdc_pkg::t_in_item  i_item,
    input  wire ifdc_pkg::t_cfg      i_cfg,
    output ifdc_pkg::t_out_item      o_result
);

    localparam logic [ifdc_pkg::CNT_W-1:0] PROTO_CNT_MAX =
        ifdc_pkg::CNT_W'(ifdc_pkg::NUM_BLOCKED_PROTOCOLS);

    function automatic logic is_ctrl_addr(input logic [ifdc_pkg::ADDR_W-1:0] a);
        logic hit;
        hit = (a[31:16] == ifdc_pkg::CTRL_NET_HI) && (a[15:9] == 7'd0);
        hit = hit || (a == ifdc_pkg::ADDR_BROADCAST) || (a == ifdc_pkg::ADDR_LOOPBACK);
        return hit;
    endfunction

    function automatic logic port_hit(
        input logic [ifdc_pkg::PORT_W-1:0] p,
        input logic [ifdc_pkg::NUM_BLOCKED_PORTS*ifdc_pkg::PORT_W-1:0] list
    );
        logic                        hit;
        logic [ifdc_pkg::PORT_W-1:0] e;
        hit = 1'b0;
        for (int k = 0; k < ifdc_pkg::NUM_BLOCKED_PORTS; k++) begin
            e = list[k*ifdc_pkg::PORT_W +: ifdc_pkg::PORT_W];
            if ((e != '0) && (e == p)) begin
                hit = 1'b1;
            end
        end
        return hit && (p != '0);
    endfunction

    logic                              has_ports;
    logic [ifdc_pkg::PORT_W-1:0]       sport;
    logic [ifdc_pkg::PORT_W-1:0]       dport;
    logic                              ctrl_drop;
    logic [ifdc_pkg::CNT_W-1:0]        proto_cnt;
    logic                              proto_drop;
    logic                              src_in_net;
    logic                              dst_in_net;
    logic                              own_ok;
    logic                              flip;
    logic                              outgoing;
    logic                              undecided;
    logic [ifdc_pkg::ADDR_W-1:0]       fsrc;
    logic [ifdc_pkg::ADDR_W-1:0]       fdst;
    logic [ifdc_pkg::PORT_W-1:0]       fsport;
    logic [ifdc_pkg::PORT_W-1:0]       fdport_raw;
    logic [ifdc_pkg::PORT_W-1:0]       fdport;
    logic                              router_drop;
    logic                              port_drop;

    // Ports count only for TCP and UDP
    assign has_ports = (i_item.protocol == ifdc_pkg::PROTO_TCP) ||
                       (i_item.protocol == ifdc_pkg::PROTO_UDP);
    assign sport = has_ports ? i_item.src_l4_port : '0;
    assign dport = has_ports ? i_item.dst_l4_port : '0;

    assign ctrl_drop = i_cfg.mode_flags[ifdc_pkg::FLAG_CTRL_FILTER] &&
                       (is_ctrl_addr(i_item.src_ip) || is_ctrl_addr(i_item.dst_ip));

    // Saturate the entry count and search the blocked protocol list
    assign proto_cnt = (i_cfg.blocked_protocol_count > PROTO_CNT_MAX) ?
                       PROTO_CNT_MAX : i_cfg.blocked_protocol_count;

    always_comb begin
        proto_drop = 1'b0;
        for (int k = 0; k < ifdc_pkg::NUM_BLOCKED_PROTOCOLS; k++) begin
            if ((ifdc_pkg::CNT_W'(k) < proto_cnt) &&
                (i_cfg.blocked_protocols[k*ifdc_pkg::PROTO_W +: ifdc_pkg::PROTO_W] ==
                 i_item.protocol)) begin
                proto_drop = 1'b1;
            end
        end
        if (i_item.protocol == '0) begin
            proto_drop = 1'b0;
        end
    end

    assign src_in_net = (i_item.src_ip & i_cfg.net_mask) == i_cfg.net_addr;
    assign dst_in_net = (i_item.dst_ip & i_cfg.net_mask) == i_cfg.net_addr;
    assign own_ok     = i_cfg.mode_flags[ifdc_pkg::FLAG_OWN_VALID];

    // Pick the direction: first match wins
    always_comb begin
        flip      = 1'b0;
        outgoing  = 1'b0;
        undecided = 1'b0;
        if (i_cfg.mode_flags[ifdc_pkg::FLAG_SUBNET]) begin
            if (src_in_net && !dst_in_net) begin
                outgoing = 1'b1;
            end else if (dst_in_net && !src_in_net) begin
                flip = 1'b1;
            end else begin
                undecided = 1'b1;
            end
        end else if (i_item.hw_dir == ifdc_pkg::HW_OUT) begin
            outgoing = 1'b1;
        end else if (i_item.hw_dir == ifdc_pkg::HW_IN) begin
            flip = 1'b1;
        end else if (own_ok && (i_item.src_ip == i_cfg.own_ip)) begin
            outgoing = 1'b1;
        end else if (own_ok && (i_item.dst_ip == i_cfg.own_ip)) begin
            flip = 1'b1;
        end else if (i_item.dst_ip[31:28] == ifdc_pkg::MCAST_NIBBLE) begin
            flip = 1'b1;
        end else if (i_cfg.mode_flags[ifdc_pkg::FLAG_CHOOSY]) begin
            undecided = 1'b1;
        end else begin
            flip = i_item.src_ip < i_item.dst_ip;
        end
    end

    // Build the flow key
    assign fsrc       = flip ? i_item.dst_ip : i_item.src_ip;
    assign fdst       = flip ? i_item.src_ip : i_item.dst_ip;
    assign fsport     = flip ? dport : sport;
    assign fdport_raw = flip ? sport : dport;
    assign fdport     = (fdport_raw >= ifdc_pkg::DYN_PORT_MIN) ? '0 : fdport_raw;

    assign router_drop = fsrc == i_cfg.gateway_ip;
    assign port_drop   = port_hit(fsport, i_cfg.blocked_ports) ||
                         port_hit(fdport, i_cfg.blocked_ports);

    // Apply the checks in order; a dropped result carries only its reason
    always_comb begin
        o_result = '0;
        if (ctrl_drop) begin
            o_result.drop_reason = ifdc_pkg::DROP_CONTROL;
        end else if (proto_drop) begin
            o_result.drop_reason = ifdc_pkg::DROP_PROTOCOL;
        end else if (undecided) begin
            o_result.drop_reason = ifdc_pkg::DROP_UNDECIDED;
        end else if (router_drop) begin
            o_result.drop_reason = ifdc_pkg::DROP_ROUTER;
        end else if (port_drop) begin
            o_result.drop_reason = ifdc_pkg::DROP_PORT;
        end else begin
            o_result.keep           = 1'b1;
            o_result.drop_reason    = ifdc_pkg::DROP_NONE;
            o_result.outgoing       = outgoing;
            o_result.flow_src       = fsrc;
            o_result.flow_dst       = fdst;
            o_result.flow_src_port  = fsport;
            o_result.flow_dst_port  = fdport;
            o_result.flow_protocol  = i_item.protocol;
            o_result.counts_as_sent = i_item.src_ip == fsrc;
            o_result.byte_count     = i_item.total_length;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ipv4_flow_direction_classifier.sv
// ----------------------------------------------------------------------------
// ipv4_flow_direction_classifier: IPv4 flow keep/drop and direction decision
// Registers each header summary, decides keep/drop, direction and flow key,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake     Carries
//  i_req     in   valid/ready   one IPv4 header summary per request
//  o_rsp     out  valid/ready   keep, drop reason and flow key per request
//  i_cfg_*   in   write enable  register index 0..7 and 64-bit data
//
//  A request passes the input register, then one decision pass into the
//  output register. One request is taken every cycle while o_rsp.ready holds.
//  A stalled result holds the output register; the input register fills
//  behind it, then i_req.ready drops. Reset (synchronous, active low) empties
//  both stages and clears all configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_flow_direction_classifier (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    ifdc_req_if.sink                        i_req,
    ifdc_rsp_if.source                      o_rsp,
    input  wire                             i_cfg_we,
    input  wire [ifdc_pkg::IDX_W-1:0]       i_cfg_idx,
    input  wire [ifdc_pkg::CFG_W-1:0]       i_cfg_data
);

    ifdc_pkg::t_cfg       r_cfg;
    ifdc_pkg::t_in_item   r_s1_item;
    logic                 r_s1_valid;
    ifdc_pkg::t_out_item  r_out_item;
    logic                 r_out_valid;
    ifdc_pkg::t_out_item  n_out_item;
    ifdc_pkg::t_in_item   req_item;
    logic                 out_free;
    logic                 s1_move;
    logic                 req_take;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (ifdc_pkg::t_cfg_idx'(i_cfg_idx))
                ifdc_pkg::CFG_MODE_FLAGS: begin
                    r_cfg.mode_flags <= i_cfg_data[ifdc_pkg::FLAGS_W-1:0];
                end
                ifdc_pkg::CFG_NET_MASK: begin
                    r_cfg.net_mask <= i_cfg_data[ifdc_pkg::ADDR_W-1:0];
                end
                ifdc_pkg::CFG_NET_ADDR: begin
                    r_cfg.net_addr <= i_cfg_data[ifdc_pkg::ADDR_W-1:0];
                end
                ifdc_pkg::CFG_OWN_IP: begin
                    r_cfg.own_ip <= i_cfg_data[ifdc_pkg::ADDR_W-1:0];
                end
                ifdc_pkg::CFG_GATEWAY_IP: begin
                    r_cfg.gateway_ip <= i_cfg_data[ifdc_pkg::ADDR_W-1:0];
                end
                ifdc_pkg::CFG_BLOCKED_PROTO: begin
                    r_cfg.blocked_protocols <=
                        i_cfg_data[ifdc_pkg::NUM_BLOCKED_PROTOCOLS*ifdc_pkg::PROTO_W-1:0];
                end
                ifdc_pkg::CFG_BLOCKED_CNT: begin
                    r_cfg.blocked_protocol_count <= i_cfg_data[ifdc_pkg::CNT_W-1:0];
                end
                ifdc_pkg::CFG_BLOCKED_PORTS: begin
                    r_cfg.blocked_ports <=
                        i_cfg_data[ifdc_pkg::NUM_BLOCKED_PORTS*ifdc_pkg::PORT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Handshake: advance when the next stage is free
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || s1_move;
    assign req_take    = i_req.valid && i_req.ready;

    assign req_item.src_ip       = i_req.src_ip;
    assign req_item.dst_ip       = i_req.dst_ip;
    assign req_item.protocol     = i_req.protocol;
    assign req_item.src_l4_port  = i_req.src_l4_port;
    assign req_item.dst_l4_port  = i_req.dst_l4_port;
    assign req_item.total_length = i_req.total_length;
    assign req_item.hw_dir       = i_req.hw_dir;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_s1_item <= req_item;
        end
    end

    ifdc_decide u_decide (
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .o_result (n_out_item)
    );

    // Output register: load a new result or hold a stalled one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.keep           = r_out_item.keep;
    assign o_rsp.drop_reason    = r_out_item.drop_reason;
    assign o_rsp.outgoing       = r_out_item.outgoing;
    assign o_rsp.flow_src       = r_out_item.flow_src;
    assign o_rsp.flow_dst       = r_out_item.flow_dst;
    assign o_rsp.flow_src_port  = r_out_item.flow_src_port;
    assign o_rsp.flow_dst_port  = r_out_item.flow_dst_port;
    assign o_rsp.flow_protocol  = r_out_item.flow_protocol;
    assign o_rsp.counts_as_sent = r_out_item.counts_as_sent;
    assign o_rsp.byte_count     = r_out_item.byte_count;

    // A kept result always carries no drop reason
    a_keep_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.keep == (r_out_item.drop_reason == ifdc_pkg::DROP_NONE)))
        else $error("keep and drop reason disagree");

    // A dropped result carries an empty flow key
    a_drop_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.keep) |->
            (r_out_item.flow_src == '0 && r_out_item.flow_dst == '0 &&
             r_out_item.byte_count == '0 && !r_out_item.counts_as_sent))
        else $error("dropped result carries key data");

    // An input held behind a stalled result stays in place
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("input stage lost a waiting request");

    // A moved request shows up at the output next cycle
    a_s1_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("request lost between stages");

endmodule

`default_nettype wire

FILE: bench/ipv4_flow_direction_classifier_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_flow_direction_classifier_test: self-checking bench of the classifier
// Drives header summaries through the request channel under random stalls on
// both sides, predicts each keep/drop decision and flow key from a private
// copy of the configuration, and checks every result in order.
// ----------------------------------------------------------------------------

module ipv4_flow_direction_classifier_test;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int PIPE_LATENCY    = 2;
    localparam int SETTLE_CYCLES   = PIPE_LATENCY + 2;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;

    // Link hints that carry no direction
    localparam logic [ifdc_pkg::HW_W-1:0] HW_UNKNOWN  = 2'd2;
    localparam logic [ifdc_pkg::HW_W-1:0] HW_RESERVED = 2'd3;

    // ------------------------------------------------------------------------
    // Decision predictor and store of expected decisions
    // ------------------------------------------------------------------------
    class flow_scoreboard;
        ifdc_pkg::t_cfg      regs;
        ifdc_pkg::t_out_item pending_decisions[$];
        int                  mismatches;
        int                  decisions_seen;

        function bit is_control(logic [ifdc_pkg::ADDR_W-1:0] a);
            return (a[31:16] == ifdc_pkg::CTRL_NET_HI && a[15:9] == '0) ||
                   a == ifdc_pkg::ADDR_BROADCAST || a == ifdc_pkg::ADDR_LOOPBACK;
        endfunction

        function bit in_net(logic [ifdc_pkg::ADDR_W-1:0] a);
            return (a & regs.net_mask) == regs.net_addr;
        endfunction

        function bit port_hit(logic [ifdc_pkg::PORT_W-1:0] p);
            logic [ifdc_pkg::PORT_W-1:0] entry;
            if (p == '0)
                return 1'b0;
            for (int k = 0; k < ifdc_pkg::NUM_BLOCKED_PORTS; k++) begin
                entry = regs.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W];
                if (entry != '0 && entry == p)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function ifdc_pkg::t_out_item dropped(ifdc_pkg::t_drop_reason why);
            ifdc_pkg::t_out_item d;
            d = '0;
            d.drop_reason = why;
            return d;
        endfunction

        function ifdc_pkg::t_out_item predict_decision(ifdc_pkg::t_in_item r);
            ifdc_pkg::t_out_item         d;
            logic [ifdc_pkg::PORT_W-1:0] sport, dport, fsport, fdport;
            logic [ifdc_pkg::ADDR_W-1:0] fsrc, fdst;
            bit                          flip, outgoing, src_in, dst_in, own;
            int unsigned                 n_proto;
            d        = '0;
            sport    = '0;
            dport    = '0;
            flip     = 1'b0;
            outgoing = 1'b0;
            own      = regs.mode_flags[ifdc_pkg::FLAG_OWN_VALID];

            // Ports exist only for TCP and UDP
            if (r.protocol == ifdc_pkg::PROTO_TCP || r.protocol == ifdc_pkg::PROTO_UDP) begin
                sport = r.src_l4_port;
                dport = r.dst_l4_port;
            end

            if (regs.mode_flags[ifdc_pkg::FLAG_CTRL_FILTER] &&
                (is_control(r.src_ip) || is_control(r.dst_ip)))
                return dropped(ifdc_pkg::DROP_CONTROL);

            // Clamp the entry count to the list size; protocol zero never matches
            n_proto = (regs.blocked_protocol_count > ifdc_pkg::NUM_BLOCKED_PROTOCOLS) ?
                      ifdc_pkg::NUM_BLOCKED_PROTOCOLS : regs.blocked_protocol_count;
            if (r.protocol != '0) begin
                for (int k = 0; k < n_proto; k++) begin
                    if (regs.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W] ==
                        r.protocol)
                        return dropped(ifdc_pkg::DROP_PROTOCOL);
                end
            end

            // Decide direction: first match wins outside subnet mode
            if (!regs.mode_flags[ifdc_pkg::FLAG_SUBNET]) begin
                if (r.hw_dir == ifdc_pkg::HW_OUT)
                    outgoing = 1'b1;
                else if (r.hw_dir == ifdc_pkg::HW_IN)
                    flip = 1'b1;
                else if (own && r.src_ip == regs.own_ip)
                    outgoing = 1'b1;
                else if (own && r.dst_ip == regs.own_ip)
                    flip = 1'b1;
                else if (r.dst_ip[31:28] == ifdc_pkg::MCAST_NIBBLE)
                    flip = 1'b1;
                else if (regs.mode_flags[ifdc_pkg::FLAG_CHOOSY])
                    return dropped(ifdc_pkg::DROP_UNDECIDED);
                else
                    flip = r.src_ip < r.dst_ip;
            end else begin
                src_in = in_net(r.src_ip);
                dst_in = in_net(r.dst_ip);
                if (src_in && !dst_in)
                    outgoing = 1'b1;
                else if (dst_in && !src_in)
                    flip = 1'b1;
                else
                    return dropped(ifdc_pkg::DROP_UNDECIDED);
            end

            // Build the flow key, swapped for incoming traffic
            if (flip) begin
                fsrc = r.dst_ip;  fdst = r.src_ip;  fsport = dport;  fdport = sport;
            end else begin
                fsrc = r.src_ip;  fdst = r.dst_ip;  fsport = sport;  fdport = dport;
            end

            if (fsrc == regs.gateway_ip)
                return dropped(ifdc_pkg::DROP_ROUTER);
            if (fdport >= ifdc_pkg::DYN_PORT_MIN)
                fdport = '0;
            if (port_hit(fsport) || port_hit(fdport))
                return dropped(ifdc_pkg::DROP_PORT);

            d.keep           = 1'b1;
            d.drop_reason    = ifdc_pkg::DROP_NONE;
            d.outgoing       = outgoing;
            d.flow_src       = fsrc;
            d.flow_dst       = fdst;
            d.flow_src_port  = fsport;
            d.flow_dst_port  = fdport;
            d.flow_protocol  = r.protocol;
            d.counts_as_sent = (r.src_ip == fsrc);
            d.byte_count     = r.total_length;
            return d;
        endfunction

        function void note_request(ifdc_pkg::t_in_item r);
            pending_decisions.push_back(predict_decision(r));
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                if (mismatches < MAX_REPORTS)
                    $display("decision %0d: %s expected %0h, got %0h",
                             decisions_seen, field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_decision(ifdc_pkg::t_out_item got);
            ifdc_pkg::t_out_item want;
            if (pending_decisions.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("decision %0d: result with no request pending",
                             decisions_seen);
                mismatches++;
                decisions_seen++;
                return;
            end
            want = pending_decisions.pop_front();
            compare_field("keep", 64'(want.keep), 64'(got.keep));
            compare_field("drop_reason", 64'(want.drop_reason), 64'(got.drop_reason));
            compare_field("outgoing", 64'(want.outgoing), 64'(got.outgoing));
            compare_field("flow_src", 64'(want.flow_src), 64'(got.flow_src));
            compare_field("flow_dst", 64'(want.flow_dst), 64'(got.flow_dst));
            compare_field("flow_src_port", 64'(want.flow_src_port),
                          64'(got.flow_src_port));
            compare_field("flow_dst_port", 64'(want.flow_dst_port),
                          64'(got.flow_dst_port));
            compare_field("flow_protocol", 64'(want.flow_protocol),
                          64'(got.flow_protocol));
            compare_field("counts_as_sent", 64'(want.counts_as_sent),
                          64'(got.counts_as_sent));
            compare_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
            decisions_seen++;
        endfunction

        function int failures();
            return mismatches + pending_decisions.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ifdc_pkg::IDX_W-1:0]     i_cfg_idx;
    logic [ifdc_pkg::CFG_W-1:0]     i_cfg_data;

    ifdc_req_if req_ch();
    ifdc_rsp_if rsp_ch();

    flow_scoreboard sb;
    bit             tx_idle_on     = 1'b1;
    bit             rx_idle_on     = 1'b1;
    int             rx_hold_cycles = 0;
    int             quiet_cycles   = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    ipv4_flow_direction_classifier DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic ifdc_pkg::t_in_item make_req(
        logic [ifdc_pkg::ADDR_W-1:0] src, logic [ifdc_pkg::ADDR_W-1:0] dst,
        logic [ifdc_pkg::PROTO_W-1:0] proto,
        logic [ifdc_pkg::PORT_W-1:0] sport, logic [ifdc_pkg::PORT_W-1:0] dport,
        logic [ifdc_pkg::LEN_W-1:0] len, logic [ifdc_pkg::HW_W-1:0] hw);
        return '{src_ip: src, dst_ip: dst, protocol: proto, src_l4_port: sport,
                 dst_l4_port: dport, total_length: len, hw_dir: hw};
    endfunction

    // Favor addresses that hit the special cases of the current setting
    function automatic logic [ifdc_pkg::ADDR_W-1:0] pick_addr(ifdc_pkg::t_cfg c);
        case ($urandom_range(0, 9))
            0: return c.own_ip;
            1: return c.gateway_ip;
            2: return (c.net_addr & c.net_mask) | ($urandom & ~c.net_mask);
            3: begin
                case ($urandom_range(0, 3))
                    0: return {ifdc_pkg::CTRL_NET_HI, 8'h00, 8'($urandom)};
                    1: return {ifdc_pkg::CTRL_NET_HI, 8'h01, 8'($urandom)};
                    2: return ifdc_pkg::ADDR_BROADCAST;
                    default: return ifdc_pkg::ADDR_LOOPBACK;
                endcase
            end
            4: return {ifdc_pkg::MCAST_NIBBLE, 28'($urandom)};
            5: return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ifdc_pkg::PORT_W-1:0] pick_port(ifdc_pkg::t_cfg c);
        int k;
        k = $urandom_range(0, ifdc_pkg::NUM_BLOCKED_PORTS - 1);
        case ($urandom_range(0, 7))
            0: return c.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W];
            1: return '0;
            2: return ifdc_pkg::DYN_PORT_MIN;
            3: return ifdc_pkg::DYN_PORT_MIN - 16'd1;
            4: return '1;
            default: return ifdc_pkg::PORT_W'($urandom);
        endcase
    endfunction

    function automatic ifdc_pkg::t_in_item random_request(ifdc_pkg::t_cfg c);
        ifdc_pkg::t_in_item r;
        int                 k;
        k = $urandom_range(0, ifdc_pkg::NUM_BLOCKED_PROTOCOLS - 1);
        r.src_ip = pick_addr(c);
        r.dst_ip = pick_addr(c);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                r.protocol = $urandom_range(0, 1) ? ifdc_pkg::PROTO_TCP : ifdc_pkg::PROTO_UDP;
            end
            6: r.protocol = c.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W];
            7: r.protocol = '0;
            default: r.protocol = ifdc_pkg::PROTO_W'($urandom);
        endcase
        r.src_l4_port  = pick_port(c);
        r.dst_l4_port  = pick_port(c);
        r.total_length = ifdc_pkg::LEN_W'($urandom);
        r.hw_dir       = ifdc_pkg::HW_W'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic ifdc_pkg::t_cfg random_setting();
        ifdc_pkg::t_cfg c;
        int             prefix;
        prefix                   = $urandom_range(0, 32);
        c.mode_flags             = ifdc_pkg::FLAGS_W'($urandom_range(0, 15));
        c.net_mask               = 32'hFFFF_FFFF << (32 - prefix);
        c.net_addr               = $urandom_range(0, 7) == 0 ? $urandom : $urandom & c.net_mask;
        c.own_ip                 = $urandom;
        c.gateway_ip             = $urandom;
        c.blocked_protocol_count = ifdc_pkg::CNT_W'($urandom_range(0, 7));
        for (int k = 0; k < ifdc_pkg::NUM_BLOCKED_PROTOCOLS; k++) begin
            case ($urandom_range(0, 5))
                0: c.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W] = '0;
                1: c.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W] = 8'd1;
                2: begin
                    c.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W] =
                        ifdc_pkg::PROTO_TCP;
                end
                3: begin
                    c.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W] =
                        ifdc_pkg::PROTO_UDP;
                end
                4: c.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W] = '1;
                default: begin
                    c.blocked_protocols[ifdc_pkg::PROTO_W*k +: ifdc_pkg::PROTO_W] =
                        ifdc_pkg::PROTO_W'($urandom);
                end
            endcase
        end
        for (int k = 0; k < ifdc_pkg::NUM_BLOCKED_PORTS; k++) begin
            case ($urandom_range(0, 5))
                0: c.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W] = '0;
                1: c.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W] = 16'd22;
                2: c.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W] = 16'd443;
                3: c.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W] = '1;
                4: begin
                    c.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W] =
                        ifdc_pkg::DYN_PORT_MIN;
                end
                default: begin
                    c.blocked_ports[ifdc_pkg::PORT_W*k +: ifdc_pkg::PORT_W] =
                        ifdc_pkg::PORT_W'($urandom);
                end
            endcase
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input ifdc_pkg::t_cfg_idx idx,
                             input logic [ifdc_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write every register, then mirror the setting into the predictor
    task automatic apply_setting(input ifdc_pkg::t_cfg c);
        write_reg(ifdc_pkg::CFG_MODE_FLAGS,    ifdc_pkg::CFG_W'(c.mode_flags));
        write_reg(ifdc_pkg::CFG_NET_MASK,      ifdc_pkg::CFG_W'(c.net_mask));
        write_reg(ifdc_pkg::CFG_NET_ADDR,      ifdc_pkg::CFG_W'(c.net_addr));
        write_reg(ifdc_pkg::CFG_OWN_IP,        ifdc_pkg::CFG_W'(c.own_ip));
        write_reg(ifdc_pkg::CFG_GATEWAY_IP,    ifdc_pkg::CFG_W'(c.gateway_ip));
        write_reg(ifdc_pkg::CFG_BLOCKED_PROTO, ifdc_pkg::CFG_W'(c.blocked_protocols));
        write_reg(ifdc_pkg::CFG_BLOCKED_CNT,   ifdc_pkg::CFG_W'(c.blocked_protocol_count));
        write_reg(ifdc_pkg::CFG_BLOCKED_PORTS, ifdc_pkg::CFG_W'(c.blocked_ports));
        i_cfg_we <= 1'b0;
        sb.regs = c;
    endtask

    // Offer one request, with an optional gap before it, and hold until taken
    task automatic send_request(input ifdc_pkg::t_in_item r);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.src_ip       <= r.src_ip;
        req_ch.dst_ip       <= r.dst_ip;
        req_ch.protocol     <= r.protocol;
        req_ch.src_l4_port  <= r.src_l4_port;
        req_ch.dst_l4_port  <= r.dst_l4_port;
        req_ch.total_length <= r.total_length;
        req_ch.hw_dir       <= r.hw_dir;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted decision has arrived
    task automatic drain_decisions();
        req_ch.valid <= 1'b0;
        while (sb.pending_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        ifdc_pkg::t_cfg c;
        // Control filter, own address, saturated protocol count, port list
        c = '{mode_flags: (4'b1 << ifdc_pkg::FLAG_CTRL_FILTER) |
                          (4'b1 << ifdc_pkg::FLAG_OWN_VALID),
              net_mask: '0, net_addr: '0, own_ip: 32'h0A00_0001,
              gateway_ip: 32'hC0A8_0101, blocked_protocols: 32'hFA01_2F00,
              blocked_protocol_count: 3'd7, blocked_ports: 64'hFFFF_01BB_0016_0000};
        apply_setting(c);
        send_request(make_req(32'hE000_0005, 32'h0A00_0009, ifdc_pkg::PROTO_UDP, 1000, 53,
                              60, HW_UNKNOWN));
        send_request(make_req(32'h0A00_0009, 32'hE000_01C8, ifdc_pkg::PROTO_UDP, 1000, 53,
                              60, ifdc_pkg::HW_OUT));
        send_request(make_req(ifdc_pkg::ADDR_BROADCAST, 32'h0A00_0009, ifdc_pkg::PROTO_TCP,
                              1, 2, 40, ifdc_pkg::HW_IN));
        send_request(make_req(32'h0A00_0009, ifdc_pkg::ADDR_LOOPBACK, ifdc_pkg::PROTO_TCP,
                              1, 2, 40, ifdc_pkg::HW_IN));
        send_request(make_req(32'hE000_0201, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 1234, 80,
                              40, HW_UNKNOWN));
        send_request(make_req(32'h0808_0808, 32'h0A00_0002, 8'd0, 1234, 22, 100,
                              ifdc_pkg::HW_IN));
        send_request(make_req(32'h0808_0808, 32'h0A00_0002, 8'd250, 7, 8, 100,
                              ifdc_pkg::HW_IN));
        send_request(make_req(32'h0808_0808, 32'h0A00_0002, 8'd47, 7, 8, 100,
                              ifdc_pkg::HW_IN));
        send_request(make_req(32'h0808_0808, 32'h0A00_0002, 8'd1, 7, 8, 100,
                              ifdc_pkg::HW_IN));
        send_request(make_req(32'h0A00_0001, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 5555, 8080,
                              52, HW_RESERVED));
        send_request(make_req(32'h0808_0808, 32'h0A00_0001, ifdc_pkg::PROTO_TCP, 443, 6000,
                              52, HW_UNKNOWN));
        send_request(make_req(32'h0808_0808, 32'hEF01_0101, ifdc_pkg::PROTO_UDP, 5000, 5001,
                              80, HW_UNKNOWN));
        send_request(make_req(32'hC0A8_0101, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 10, 20, 40,
                              ifdc_pkg::HW_OUT));
        send_request(make_req(32'h0808_0808, 32'hC0A8_0101, ifdc_pkg::PROTO_TCP, 10, 20, 40,
                              ifdc_pkg::HW_IN));
        send_request(make_req(32'h0A00_0005, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 1234, 50000,
                              40, ifdc_pkg::HW_OUT));
        send_request(make_req(32'h0A00_0005, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 1234, 22,
                              40, ifdc_pkg::HW_OUT));
        send_request(make_req(32'h0A00_0005, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 16'hFFFF,
                              80, 40, ifdc_pkg::HW_OUT));
        send_request(make_req(32'h0A00_0005, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 0, 0, 40,
                              ifdc_pkg::HW_OUT));
        send_request(make_req(32'h0A00_0005, 32'h0808_0808, ifdc_pkg::PROTO_UDP, 1000,
                              16'hFFFF, 40, ifdc_pkg::HW_OUT));
        send_request(make_req(32'h0000_0000, 32'hFFFF_FFFE, 8'hFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, HW_UNKNOWN));
        drain_decisions();

        // Subnet direction
        c = '0;
        c.mode_flags = 4'b1 << ifdc_pkg::FLAG_SUBNET;
        c.net_mask   = 32'hFFFF_FF00;
        c.net_addr   = 32'hC0A8_0100;
        apply_setting(c);
        send_request(make_req(32'hC0A8_0105, 32'h0808_0808, ifdc_pkg::PROTO_TCP, 3000, 80,
                              40, HW_UNKNOWN));
        send_request(make_req(32'h0808_0808, 32'hC0A8_0107, ifdc_pkg::PROTO_TCP, 1111, 2222,
                              40, ifdc_pkg::HW_OUT));
        send_request(make_req(32'hC0A8_0105, 32'hC0A8_0107, ifdc_pkg::PROTO_TCP, 1, 2, 40,
                              ifdc_pkg::HW_IN));
        send_request(make_req(32'h0808_0808, 32'h0909_0909, ifdc_pkg::PROTO_TCP, 1, 2, 40,
                              ifdc_pkg::HW_IN));
        drain_decisions();

        // Choosy drop of undecided packets
        c = '0;
        c.mode_flags = 4'b1 << ifdc_pkg::FLAG_CHOOSY;
        apply_setting(c);
        send_request(make_req(32'h0808_0808, 32'h0909_0909, ifdc_pkg::PROTO_UDP, 1, 2, 40,
                              HW_UNKNOWN));
        send_request(make_req(32'h0808_0808, 32'hE000_0001, ifdc_pkg::PROTO_UDP, 1, 2, 40,
                              HW_UNKNOWN));
        drain_decisions();
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random stall bursts and one long hold on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int hold;
        forever begin
            if (rx_hold_cycles > 0) begin
                hold           = rx_hold_cycles;
                rx_hold_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request('{src_ip: req_ch.src_ip, dst_ip: req_ch.dst_ip,
                                  protocol: req_ch.protocol,
                                  src_l4_port: req_ch.src_l4_port,
                                  dst_l4_port: req_ch.dst_l4_port,
                                  total_length: req_ch.total_length,
                                  hw_dir: req_ch.hw_dir});
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_decision('{keep: rsp_ch.keep,
                                    drop_reason:
                                        ifdc_pkg::t_drop_reason'(rsp_ch.drop_reason),
                                    outgoing: rsp_ch.outgoing, flow_src: rsp_ch.flow_src,
                                    flow_dst: rsp_ch.flow_dst,
                                    flow_src_port: rsp_ch.flow_src_port,
                                    flow_dst_port: rsp_ch.flow_dst_port,
                                    flow_protocol: rsp_ch.flow_protocol,
                                    counts_as_sent: rsp_ch.counts_as_sent,
                                    byte_count: rsp_ch.byte_count});
        end
    end

    // Watchdog: end the run after a long stretch with no handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        ifdc_pkg::t_cfg setting;
        sb = new();
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= ifdc_pkg::CFG_MODE_FLAGS;
        i_cfg_data          <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.src_ip       <= '0;
        req_ch.dst_ip       <= '0;
        req_ch.protocol     <= '0;
        req_ch.src_l4_port  <= '0;
        req_ch.dst_l4_port  <= '0;
        req_ch.total_length <= '0;
        req_ch.hw_dir       <= ifdc_pkg::HW_IN;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Random phases: all-zero and all-ones settings first, idling off at the end
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 0)
                setting = '0;
            else if (p == 1)
                setting = '1;
            else
                setting = random_setting();
            apply_setting(setting);
            tx_idle_on = (p != NUM_PHASES - 1);
            rx_idle_on = (p != NUM_PHASES - 1);
            if (p == 3)
                rx_hold_cycles = LONG_HOLD;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 4 && n == ITEMS_PER_PHASE / 2)
                    drain_decisions();
                send_request(random_request(setting));
            end
            drain_decisions();
        end

        if (sb.failures() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
